// ----- hdl/gbe_pkg.sv -----
package gbe_pkg;

    localparam int CAPACITY = 1024;
    localparam int PTR_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int MODE_W = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W = 10;
    localparam int STATUS_W = 2;
    localparam int LEN_W = 11;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_LEFT      = 3'd1,
        OP_RIGHT     = 3'd2,
        OP_BACKSPACE = 3'd3,
        OP_DELETE    = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_BOUND = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fin;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic mem_op;
    } dp_status_t;

endpackage

// ----- hdl/gbe_ctrl.sv -----
module gbe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gbe_pkg::dp_status_t sts,
    output gbe_pkg::cmd_t       cmd
);

    gbe_pkg::state_t state_reg;
    gbe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            gbe_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = gbe_pkg::S_EXEC;
                end
            end
            gbe_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.mem_op)
                begin
                    state_next = gbe_pkg::S_FIN;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = gbe_pkg::S_IDLE;
                end
            end
            gbe_pkg::S_FIN:
            begin
                cmd.fin = 1'b1;
                cmd.finish = 1'b1;
                state_next = gbe_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gbe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/gbe_dp.sv -----
module gbe_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gbe_pkg::cmd_t                  cmd,
    output gbe_pkg::dp_status_t            sts,
    input  logic [gbe_pkg::MODE_W-1:0]     mode,
    input  logic [gbe_pkg::CHAR_W-1:0]     char_in,
    input  logic [gbe_pkg::POS_W-1:0]      read_pos,
    output logic                           done,
    output logic [gbe_pkg::STATUS_W-1:0]   status,
    output logic [gbe_pkg::CHAR_W-1:0]     read_char,
    output logic [gbe_pkg::LEN_W-1:0]      cursor_pos,
    output logic [gbe_pkg::LEN_W-1:0]      text_length
);

    localparam logic [gbe_pkg::PTR_W-1:0] CAP_P = gbe_pkg::PTR_W'(gbe_pkg::CAPACITY);

    logic [gbe_pkg::CHAR_W-1:0] mem [gbe_pkg::CAPACITY];

    logic [gbe_pkg::MODE_W-1:0]   op_reg;
    logic [gbe_pkg::CHAR_W-1:0]   char_reg;
    logic [gbe_pkg::POS_W-1:0]    pos_reg;
    logic [gbe_pkg::PTR_W-1:0]    gs_reg;
    logic [gbe_pkg::PTR_W-1:0]    gs_next;
    logic [gbe_pkg::PTR_W-1:0]    ge_reg;
    logic [gbe_pkg::PTR_W-1:0]    ge_next;
    logic [gbe_pkg::ADDR_W-1:0]   wr_addr_reg;
    logic [gbe_pkg::CHAR_W-1:0]   rd_data_reg;
    logic [gbe_pkg::STATUS_W-1:0] status_reg;
    logic [gbe_pkg::STATUS_W-1:0] status_next;
    logic [gbe_pkg::CHAR_W-1:0]   read_char_reg;
    logic                         done_reg;

    logic [gbe_pkg::PTR_W-1:0]    gap_len;
    logic [gbe_pkg::PTR_W-1:0]    len;
    logic [gbe_pkg::PTR_W-1:0]    pos_ext;
    logic [gbe_pkg::PTR_W-1:0]    phys;
    logic                         in_range;
    logic                         mem_op;
    logic                         mem_we;
    logic [gbe_pkg::ADDR_W-1:0]   mem_waddr;
    logic [gbe_pkg::CHAR_W-1:0]   mem_wdata;
    logic                         mem_re;
    logic [gbe_pkg::ADDR_W-1:0]   mem_raddr;
    logic [gbe_pkg::ADDR_W-1:0]   move_waddr;

    assign gap_len = ge_reg - gs_reg;
    assign len = CAP_P - gap_len;
    assign pos_ext = gbe_pkg::PTR_W'(pos_reg);
    assign in_range = pos_ext < len;
    assign phys = (pos_ext < gs_reg) ? pos_ext : pos_ext + gap_len;

    always_comb
    begin
        gs_next = gs_reg;
        ge_next = ge_reg;
        status_next = gbe_pkg::ST_DONE;
        mem_op = 1'b0;
        mem_we = 1'b0;
        mem_waddr = gs_reg[gbe_pkg::ADDR_W-1:0];
        mem_wdata = char_reg;
        mem_re = 1'b0;
        mem_raddr = phys[gbe_pkg::ADDR_W-1:0];
        move_waddr = wr_addr_reg;
        case (op_reg)
            gbe_pkg::OP_INSERT:
            begin
                if (gs_reg < ge_reg)
                begin
                    mem_we = cmd.exec;
                    gs_next = gs_reg + 1'b1;
                end
                else
                begin
                    status_next = gbe_pkg::ST_FULL;
                end
            end
            gbe_pkg::OP_LEFT:
            begin
                if (gs_reg != '0)
                begin
                    mem_op = 1'b1;
                    gs_next = gs_reg - 1'b1;
                    ge_next = ge_reg - 1'b1;
                    mem_re = cmd.exec;
                    mem_raddr = gs_next[gbe_pkg::ADDR_W-1:0];
                    move_waddr = ge_next[gbe_pkg::ADDR_W-1:0];
                end
                else
                begin
                    status_next = gbe_pkg::ST_BOUND;
                end
            end
            gbe_pkg::OP_RIGHT:
            begin
                if (ge_reg != CAP_P)
                begin
                    mem_op = 1'b1;
                    gs_next = gs_reg + 1'b1;
                    ge_next = ge_reg + 1'b1;
                    mem_re = cmd.exec;
                    mem_raddr = ge_reg[gbe_pkg::ADDR_W-1:0];
                    move_waddr = gs_reg[gbe_pkg::ADDR_W-1:0];
                end
                else
                begin
                    status_next = gbe_pkg::ST_BOUND;
                end
            end
            gbe_pkg::OP_BACKSPACE:
            begin
                if (gs_reg != '0)
                begin
                    gs_next = gs_reg - 1'b1;
                end
                else
                begin
                    status_next = gbe_pkg::ST_BOUND;
                end
            end
            gbe_pkg::OP_DELETE:
            begin
                if (ge_reg != CAP_P)
                begin
                    ge_next = ge_reg + 1'b1;
                end
                else
                begin
                    status_next = gbe_pkg::ST_BOUND;
                end
            end
            gbe_pkg::OP_READ:
            begin
                if (in_range)
                begin
                    mem_op = 1'b1;
                    mem_re = cmd.exec;
                end
                else
                begin
                    status_next = gbe_pkg::ST_RANGE;
                end
            end
            default:
            begin
                status_next = gbe_pkg::ST_DONE;
            end
        endcase
        if (cmd.fin)
        begin
            mem_re = 1'b0;
            mem_we = (op_reg == gbe_pkg::OP_LEFT) || (op_reg == gbe_pkg::OP_RIGHT);
            mem_waddr = wr_addr_reg;
            mem_wdata = rd_data_reg;
        end
    end

    assign sts.mem_op = mem_op;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= mode;
            char_reg <= char_in;
            pos_reg <= read_pos;
        end
        if (cmd.exec)
        begin
            wr_addr_reg <= move_waddr;
            status_reg <= status_next;
            read_char_reg <= '0;
        end
        if (cmd.fin && (op_reg == gbe_pkg::OP_READ))
        begin
            read_char_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg <= '0;
            ge_reg <= CAP_P;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.exec)
            begin
                gs_reg <= gs_next;
                ge_reg <= ge_next;
            end
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign read_char = read_char_reg;
    assign cursor_pos = gbe_pkg::LEN_W'(gs_reg);
    assign text_length = gbe_pkg::LEN_W'(len);

endmodule

// ----- hdl/gap_buffer_editor_unit.sv -----
// Gap buffer text editor core with a fixed store of 1024 bytes.
// An operation beat is accepted at a rising edge where start is high and
// busy is low; mode selects insert, left, right, backspace, delete or read,
// with char_in giving the inserted byte and read_pos the position to read.
// Every operation yields exactly one result beat: done is high for one
// cycle while status, read_char, cursor_pos and text_length hold the result.
// Insert, backspace, delete, refused operations and unused modes finish in
// the execute state; left, right and in-range reads pass through a further
// finish state, since they read the text memory, whose data is registered,
// before the byte is returned or written back across the gap.
// busy falls in the cycle the result is shown, so a new operation can be
// accepted together with it. cursor_pos and text_length follow the gap
// pointers and stay valid between operations. Reset empties the text and
// puts the cursor at position zero; memory contents are not cleared. The
// receiver cannot stall, so results are never held back.
module gap_buffer_editor_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [gbe_pkg::MODE_W-1:0]   mode,
    input  logic [gbe_pkg::CHAR_W-1:0]   char_in,
    input  logic [gbe_pkg::POS_W-1:0]    read_pos,
    output logic                         done,
    output logic [gbe_pkg::STATUS_W-1:0] status,
    output logic [gbe_pkg::CHAR_W-1:0]   read_char,
    output logic [gbe_pkg::LEN_W-1:0]    cursor_pos,
    output logic [gbe_pkg::LEN_W-1:0]    text_length
);

    gbe_pkg::cmd_t       cmd;
    gbe_pkg::dp_status_t sts;

    gbe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    gbe_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .mode        (mode),
        .char_in     (char_in),
        .read_pos    (read_pos),
        .done        (done),
        .status      (status),
        .read_char   (read_char),
        .cursor_pos  (cursor_pos),
        .text_length (text_length)
    );

endmodule
